@@ sv/vasp_pkg.sv @@
package vasp_pkg;

  localparam int SIG_LEN = 22;

  typedef enum logic [1:0] {
    KIND_AUDIO  = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_SIG       = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_CHECK     = 4'd3,
    ERR_OTYPE     = 4'd4,
    ERR_T8LEN     = 4'd5,
    ERR_T8NEXT    = 4'd6,
    ERR_CODEC     = 4'd7,
    ERR_TRUNCATED = 4'd8
  } err_t;

  typedef enum logic [4:0] {
    PH_SIG, PH_VER, PH_CHK, PH_OTYPE, PH_LEN1, PH_LEN8, PH_LEN9, PH_HDR1,
    PH_HDR8, PH_T8NEXT, PH_LEN81, PH_SKIP81, PH_HDR9, PH_DATA, PH_BTYPE,
    PH_LENC, PH_LENS, PH_SKIP, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV,
    CS_OUT
  } ctl_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic [31:0] sample_rate;
    logic [4:0]  bits_per_sample;
    logic [7:0]  channel_count;
    logic [15:0] format_tag;
    logic [23:0] first_block_bytes;
    logic [31:0] data_total;
    logic [3:0]  error_code;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // register input byte, run the step
    logic div_start;
    logic pop;       // one pending result taken
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       need_div;
    logic       div_done;
    logic [1:0] pending;
  } dp_stat_t;

  function automatic logic [7:0] sig_byte(input logic [4:0] i);
    logic [7:0] r;
    case (i)
      5'd0: r = 8'h43;  5'd1: r = 8'h72;  5'd2: r = 8'h65;  5'd3: r = 8'h61;
      5'd4: r = 8'h74;  5'd5: r = 8'h69;  5'd6: r = 8'h76;  5'd7: r = 8'h65;
      5'd8: r = 8'h20;  5'd9: r = 8'h56;  5'd10: r = 8'h6F; 5'd11: r = 8'h69;
      5'd12: r = 8'h63; 5'd13: r = 8'h65; 5'd14: r = 8'h20; 5'd15: r = 8'h46;
      5'd16: r = 8'h69; 5'd17: r = 8'h6C; 5'd18: r = 8'h65; 5'd19: r = 8'h1A;
      5'd20: r = 8'h1A; 5'd21: r = 8'h00;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ sv/vasp_if.sv @@
interface vasp_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/vasp_div.sv @@
module vasp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;
endmodule

@@ sv/vasp_ctl.sv @@
module vasp_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vasp_pkg::dp_stat_t  stat,
  output vasp_pkg::dp_cmd_t   cmd
);
  import vasp_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= CS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CS_OUT;
        end
      end
      CS_OUT: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = CS_DIV;
        end else begin
          out_valid = stat.pending != 2'd0;
          if (stat.pending == 2'd0) begin
            in_ready = 1'b1;
            if (in_valid) cmd.load = 1'b1;
            else          state_next = CS_IDLE;
          end else if (out_ready) begin
            cmd.pop = 1'b1;
            if (stat.pending == 2'd1) begin
              in_ready = 1'b1;
              if (in_valid) cmd.load = 1'b1;
              else          state_next = CS_IDLE;
            end
          end
        end
      end
      CS_DIV: begin
        if (stat.div_done) state_next = CS_OUT;
      end
      default: state_next = CS_IDLE;
    endcase
  end
endmodule

@@ sv/vasp_dp.sv @@
module vasp_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  vasp_pkg::item_t    item,
  input  vasp_pkg::dp_cmd_t  cmd,
  output vasp_pkg::dp_stat_t stat,
  output vasp_pkg::result_t  head
);
  import vasp_pkg::*;

  phase_t      phase;
  logic [4:0]  fidx;
  logic [15:0] ver;
  logic [23:0] brem;
  logic [15:0] tc;
  logic [31:0] rate;
  logic [7:0]  bits;
  logic [7:0]  chans;
  logic [15:0] codec;
  logic [COUNT_WIDTH-1:0] passed;

  result_t     q0, q1;
  logic [1:0]  pend;
  logic        need_div;
  logic        div_fin;  // final flag of the item waiting on the divider

  logic [31:0] div_a, div_b, div_q;
  logic        div_done;
  logic [31:0] mul_p;
  logic [23:0] brem_len;

  vasp_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .done(div_done)
  );

  assign mul_p = 32'(chans) * (32'd65536 - 32'(tc));

  always_comb begin
    if (phase == PH_T8NEXT) begin
      div_a = 32'd256000000;
      div_b = mul_p;
    end else begin
      div_a = 32'd1000000;
      div_b = 32'd256 - 32'(tc[7:0]);
    end
  end

  assign stat.need_div = need_div;
  assign stat.div_done = div_done;
  assign stat.pending  = pend;
  assign head          = q0;

  function automatic result_t blank(input kind_t k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    logic [7:0]  b;
    logic [23:0] bl;
    logic [1:0]  n;
    result_t     r0, r1, rr;
    logic        fin;
    logic        done_now;
    phase_t      ph;
    logic [4:0]  fi;
    logic [23:0] br;
    logic [15:0] vw, t16, cv;
    logic [31:0] rv;
    logic [7:0]  bv, chv;
    logic [COUNT_WIDTH-1:0] pc;
    logic        defer;
    if (rst) begin
      phase    <= PH_SIG;
      fidx     <= '0; ver <= '0; brem <= '0; tc <= '0; rate <= '0;
      bits     <= '0; chans <= '0; codec <= '0; passed <= '0;
      pend     <= '0;
      need_div <= 1'b0;
      div_fin  <= 1'b0;
    end else if (div_done) begin
      // divider result completes a header step
      rr = blank(KIND_FORMAT);
      ph = phase; fi = fidx; br = brem;
      if (phase == PH_T8NEXT) begin
        rate <= div_q;
        n = 2'd0;
        r0 = '0;
      end else begin
        rr.sample_rate       = div_q;
        rr.bits_per_sample   = 5'd8;
        rr.channel_count     = 8'd1;
        rr.format_tag        = codec;
        rr.first_block_bytes = brem;
        rate <= div_q;
        bits <= 8'd8; chans <= 8'd1;
        ph = (brem != 0) ? PH_DATA : PH_BTYPE;
        fi = '0;
        n = 2'd1;
        r0 = rr;
      end
      r1 = '0;
      if (div_fin) begin
        rr = (ph == PH_BTYPE) ? blank(KIND_END) : blank(KIND_ERROR);
        if (ph == PH_BTYPE) rr.data_total = (passed > COUNT_WIDTH'(32'hFFFFFFFF)) ?
          32'hFFFFFFFF : 32'(passed);
        else rr.error_code = ERR_TRUNCATED;
        if (n == 2'd0) r0 = rr; else r1 = rr;
        n = n + 2'd1;
        phase <= PH_SIG; fidx <= '0; ver <= '0; brem <= '0; tc <= '0; rate <= '0;
        bits <= '0; chans <= '0; codec <= '0; passed <= '0;
      end else begin
        phase <= ph; fidx <= fi; brem <= br;
      end
      if (n == 2'd1) r0.run_end = 1'b1;
      if (n == 2'd2) r1.run_end = 1'b1;
      q0 <= r0; q1 <= r1; pend <= n;
      need_div <= 1'b0;
    end else if (cmd.load) begin
      b = item.file_byte; fin = item.final_byte;
      ph = phase; fi = fidx; br = brem; vw = ver; t16 = tc; rv = rate;
      bv = bits; chv = chans; cv = codec; pc = passed;
      n = 2'd0; r0 = '0; r1 = '0; defer = 1'b0;
      bl = br | (24'(b) << (8 * fi[1:0]));
      done_now = fi >= 5'd2;
      case (phase)
        PH_SIG: begin
          if (fi >= 5'(SIG_LEN) || b != sig_byte(fi)) begin
            r0 = blank(KIND_ERROR); r0.error_code = ERR_SIG; n = 2'd1; ph = PH_DONE;
          end else if (fi == 5'(SIG_LEN - 1)) begin
            ph = PH_VER; fi = '0; vw = '0;
          end else fi = fi + 5'd1;
        end
        PH_VER: begin
          vw = vw | (16'(b) << (8 * fi[0]));
          if (fi >= 5'd1) begin
            if (vw != 16'h010A && vw != 16'h0114) begin
              r0 = blank(KIND_ERROR); r0.error_code = ERR_VERSION; n = 2'd1; ph = PH_DONE;
            end else begin ph = PH_CHK; fi = '0; t16 = '0; end
          end else fi = 5'd1;
        end
        PH_CHK: begin
          t16 = t16 | (16'(b) << (8 * fi[0]));
          if (fi >= 5'd1) begin
            if (t16 != 16'(~vw + 16'h1234)) begin
              r0 = blank(KIND_ERROR); r0.error_code = ERR_CHECK; n = 2'd1; ph = PH_DONE;
            end else begin ph = PH_OTYPE; fi = '0; t16 = '0; end
          end else fi = 5'd1;
        end
        PH_OTYPE: begin
          br = '0; fi = '0;
          if (b == 8'd1) ph = PH_LEN1;
          else if (b == 8'd8) ph = PH_LEN8;
          else if (b == 8'd9) ph = PH_LEN9;
          else begin
            r0 = blank(KIND_ERROR); r0.error_code = ERR_OTYPE; n = 2'd1; ph = PH_DONE;
          end
        end
        PH_LEN1, PH_LEN81, PH_LEN9, PH_LEN8, PH_LENC, PH_LENS: begin
          br = bl;
          if (done_now) begin
            fi = '0;
            case (phase)
              PH_LEN1: begin
                br = (bl > 24'd2) ? bl - 24'd2 : '0; ph = PH_HDR1;
              end
              PH_LEN81: begin
                br = (bl > 24'd2) ? bl - 24'd2 : '0; ph = PH_SKIP81;
              end
              PH_LEN9: begin
                br = (bl > 24'd12) ? bl - 24'd12 : '0; rv = '0; cv = '0; ph = PH_HDR9;
              end
              PH_LEN8: begin
                if (bl != 24'd4) begin
                  r0 = blank(KIND_ERROR); r0.error_code = ERR_T8LEN; n = 2'd1;
                  ph = PH_DONE;
                end else begin t16 = '0; ph = PH_HDR8; end
              end
              PH_LENC: ph = (bl != 0) ? PH_DATA : PH_BTYPE;
              default: ph = (bl != 0) ? PH_SKIP : PH_BTYPE;
            endcase
          end else fi = fi + 5'd1;
        end
        PH_HDR1: begin
          if (fi == 5'd0) begin t16 = 16'(b); fi = 5'd1; end
          else begin cv = 16'(b); defer = 1'b1; end
        end
        PH_HDR8: begin
          if (fi <= 5'd1) begin
            t16 = t16 | (16'(b) << (8 * fi[0])); fi = fi + 5'd1;
          end else if (fi == 5'd2) begin cv = 16'(b); fi = 5'd3; end
          else begin
            chv = (b == 8'hFF) ? 8'hFF : b + 8'd1;
            bv = 8'd8; ph = PH_T8NEXT; fi = '0;
            defer = 1'b1;
          end
        end
        PH_T8NEXT: begin
          if (b != 8'd1) begin
            r0 = blank(KIND_ERROR); r0.error_code = ERR_T8NEXT; n = 2'd1; ph = PH_DONE;
          end else begin br = '0; fi = '0; ph = PH_LEN81; end
        end
        PH_SKIP81, PH_HDR9: begin
          if (phase == PH_HDR9) begin
            if (fi <= 5'd3) rv = rv | (32'(b) << (8 * fi[1:0]));
            else if (fi == 5'd4) bv = b;
            else if (fi == 5'd5) chv = b;
            else if (fi <= 5'd7) cv = cv | (16'(b) << (8 * fi[0]));
          end
          if (phase == PH_HDR9 && fi == 5'd7 && ((bv != 8'd8 && bv != 8'd16) ||
              (cv != 16'd0 && cv != 16'd4))) begin
            r0 = blank(KIND_ERROR); r0.error_code = ERR_CODEC; n = 2'd1; ph = PH_DONE;
          end else if ((phase == PH_HDR9 && fi >= 5'd11) ||
                       (phase == PH_SKIP81 && fi != 5'd0)) begin
            r0 = blank(KIND_FORMAT);
            r0.sample_rate = rv; r0.bits_per_sample = bv[4:0];
            r0.channel_count = chv; r0.format_tag = cv; r0.first_block_bytes = br;
            n = 2'd1;
            ph = (br != 0) ? PH_DATA : PH_BTYPE; fi = '0;
          end else fi = fi + 5'd1;
        end
        PH_DATA: begin
          r0 = blank(KIND_AUDIO); r0.audio_byte = b; n = 2'd1;
          if (pc != '1) pc = pc + 1'b1;
          if (br != 0) br = br - 24'd1;
          if (br == 0) ph = PH_BTYPE;
        end
        PH_BTYPE: begin
          br = '0; fi = '0;
          if (b == 8'd2) ph = PH_LENC;
          else if (b >= 8'd3 && b <= 8'd7) ph = PH_LENS;
          else begin
            r0 = blank(KIND_END);
            r0.data_total = (pc > COUNT_WIDTH'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(pc);
            n = 2'd1; ph = PH_DONE;
          end
        end
        PH_SKIP: begin
          if (br != 0) br = br - 24'd1;
          if (br == 0) ph = PH_BTYPE;
        end
        default: ;
      endcase
      if (defer) begin
        phase <= ph; fidx <= fi; brem <= br; ver <= vw; tc <= t16; rate <= rv;
        bits <= bv; chans <= chv; codec <= cv; passed <= pc;
        need_div <= 1'b1; div_fin <= fin; pend <= '0;
      end else begin
        if (fin) begin
          if (ph == PH_BTYPE) begin
            rr = blank(KIND_END);
            rr.data_total = (pc > COUNT_WIDTH'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(pc);
          end else if (ph != PH_DONE) begin
            rr = blank(KIND_ERROR); rr.error_code = ERR_TRUNCATED;
          end else rr = '0;
          if (ph != PH_DONE) begin
            if (n == 2'd0) r0 = rr; else r1 = rr;
            n = n + 2'd1;
          end
          phase <= PH_SIG; fidx <= '0; ver <= '0; brem <= '0; tc <= '0; rate <= '0;
          bits <= '0; chans <= '0; codec <= '0; passed <= '0;
        end else begin
          phase <= ph; fidx <= fi; brem <= br; ver <= vw; tc <= t16; rate <= rv;
          bits <= bv; chans <= chv; codec <= cv; passed <= pc;
        end
        if (n == 2'd1) r0.run_end = 1'b1;
        if (n == 2'd2) r1.run_end = 1'b1;
        q0 <= r0; q1 <= r1; pend <= n;
      end
    end else if (cmd.pop) begin
      q0   <= q1;
      pend <= pend - 2'd1;
    end
  end
endmodule

@@ sv/voc_audio_stream_parser.sv @@
// VOC audio stream parser.
// in_ch  (sink):   one file byte per request, file_byte plus final_byte.
// out_ch (source): result requests: audio bytes, one format record,
//                  an end record or an error record; run_end marks the
//                  last result of an input byte.
// An input byte's first result is valid the cycle after it is accepted,
// unless the byte needs the divider. Audio bytes stream at one byte per
// cycle while the sink keeps ready high, since the next byte is taken in
// the cycle its result drains. Bytes that cause no result also pass at one
// per cycle. The format record of a type 1 or type 8 header needs the
// 32-step restoring divider; no new byte is taken while it runs. A byte
// with two results (data plus end/error) holds input until both drain.
// Reset (rst, synchronous) returns to awaiting the signature with all counts
// cleared; a byte with final_byte set re-arms the parser the same way.
// A stalled sink holds pending results, and then no new byte is taken.
module voc_audio_stream_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input logic clk,
  input logic rst,
  vasp_if.sink   in_ch,
  vasp_if.source out_ch
);
  import vasp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  head;

  vasp_ctl u_ctl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  vasp_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .item(in_ch.data), .cmd(cmd), .stat(stat), .head(head)
  );

  assign out_ch.data = head;

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> stat.pending != 2'd0) else $error("pop with nothing pending");
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !stat.need_div) else $error("input taken during divide");
  a_pend_max: assert property (@(posedge clk) disable iff (rst)
    stat.pending <= 2'd2) else $error("pending overflow");
endmodule

@@ tb/sv/tb_voc_audio_stream_parser.sv @@
module tb_voc_audio_stream_parser;
  import vasp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  int   cycles;
  int   errors;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   stim_done;
  bit   in_taken;

  vasp_if #(item_t)   in_ch  (clk);
  vasp_if #(result_t) out_ch (clk);

  voc_audio_stream_parser u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  localparam logic [7:0] SIG [SIG_LEN] = '{
    8'h43, 8'h72, 8'h65, 8'h61, 8'h74, 8'h69, 8'h76, 8'h65, 8'h20, 8'h56, 8'h6F,
    8'h69, 8'h63, 8'h65, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65, 8'h1A, 8'h1A, 8'h00};
  localparam int LIMIT = 2000000;

  // parser image
  phase_t      ph;
  logic [4:0]  fidx;
  logic [15:0] ver;
  logic [23:0] remain;
  logic [15:0] tconst;
  logic [31:0] rate;
  logic [7:0]  bits;
  logic [7:0]  chans;
  logic [15:0] codec;
  logic [31:0] passed;

  item_t   pending_bytes[$];
  result_t expected_results[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    ph = PH_SIG; fidx = '0; ver = '0; remain = '0; tconst = '0; rate = '0;
    bits = '0; chans = '0; codec = '0; passed = '0;
  endfunction

  function automatic void push_rec(kind_t k, logic [7:0] ab, logic [31:0] tot,
                                   err_t ec, bit fmt);
    result_t r;
    r = '0;
    r.kind = k;
    r.audio_byte = ab;
    if (fmt) begin
      r.sample_rate = rate;
      r.bits_per_sample = bits[4:0];
      r.channel_count = chans;
      r.format_tag = codec;
      r.first_block_bytes = remain;
      ph = (remain != 0) ? PH_DATA : PH_BTYPE;
      fidx = '0;
    end
    r.data_total = tot;
    r.error_code = ec;
    if (k == KIND_END || k == KIND_ERROR) ph = PH_DONE;
    expected_results.push_back(r);
  endfunction

  function automatic bit take_len(logic [7:0] b);
    remain = remain | (24'(b) << (8 * fidx[1:0]));
    if (fidx >= 2) begin
      fidx = '0;
      return 1'b1;
    end
    fidx = fidx + 5'd1;
    return 1'b0;
  endfunction

  function automatic logic [23:0] sub_sat(logic [23:0] v, logic [23:0] d);
    return (v > d) ? v - d : 24'd0;
  endfunction

  function automatic void parse_byte(item_t it);
    logic [7:0] b;
    logic [4:0] fi;
    logic [63:0] div;
    logic [15:0] want;
    int n0;
    b = it.file_byte;
    fi = fidx;
    n0 = expected_results.size();
    case (ph)
      PH_SIG:
        if (fi >= SIG_LEN || b != SIG[fi]) push_rec(KIND_ERROR, 0, 0, ERR_SIG, 0);
        else if (fi == SIG_LEN - 1) begin
          ph = PH_VER; fidx = '0; ver = '0;
        end else fidx = fi + 5'd1;
      PH_VER: begin
        ver = ver | (16'(b) << (8 * fi[0]));
        if (fi >= 1) begin
          if (ver != 16'h10A && ver != 16'h114) push_rec(KIND_ERROR, 0, 0, ERR_VERSION, 0);
          else begin
            ph = PH_CHK; fidx = '0; tconst = '0;
          end
        end else fidx = 5'd1;
      end
      PH_CHK: begin
        tconst = tconst | (16'(b) << (8 * fi[0]));
        if (fi >= 1) begin
          want = ~ver + 16'h1234;
          if (tconst != want) push_rec(KIND_ERROR, 0, 0, ERR_CHECK, 0);
          else begin
            ph = PH_OTYPE; fidx = '0; tconst = '0;
          end
        end else fidx = 5'd1;
      end
      PH_OTYPE: begin
        remain = '0; fidx = '0;
        if (b == 1) ph = PH_LEN1;
        else if (b == 8) ph = PH_LEN8;
        else if (b == 9) ph = PH_LEN9;
        else push_rec(KIND_ERROR, 0, 0, ERR_OTYPE, 0);
      end
      PH_LEN1:
        if (take_len(b)) begin
          remain = sub_sat(remain, 2); ph = PH_HDR1;
        end
      PH_LEN8:
        if (take_len(b)) begin
          if (remain != 4) push_rec(KIND_ERROR, 0, 0, ERR_T8LEN, 0);
          else begin
            tconst = '0; ph = PH_HDR8;
          end
        end
      PH_LEN9:
        if (take_len(b)) begin
          remain = sub_sat(remain, 12); rate = '0; codec = '0; ph = PH_HDR9;
        end
      PH_HDR1:
        if (fi == 0) begin
          tconst = 16'(b); fidx = 5'd1;
        end else begin
          codec = 16'(b); bits = 8; chans = 1;
          rate = 32'd1000000 / (32'd256 - 32'(tconst[7:0]));
          push_rec(KIND_FORMAT, 0, 0, ERR_NONE, 1);
        end
      PH_HDR8:
        if (fi <= 1) begin
          tconst = tconst | (16'(b) << (8 * fi[0])); fidx = fi + 5'd1;
        end else if (fi == 2) begin
          codec = 16'(b); fidx = 5'd3;
        end else begin
          chans = (b == 8'hFF) ? 8'hFF : b + 8'd1;
          bits = 8;
          div = 64'(chans) * (64'd65536 - 64'(tconst));
          rate = 32'(64'd256000000 / div);
          ph = PH_T8NEXT; fidx = '0;
        end
      PH_T8NEXT:
        if (b != 1) push_rec(KIND_ERROR, 0, 0, ERR_T8NEXT, 0);
        else begin
          remain = '0; fidx = '0; ph = PH_LEN81;
        end
      PH_LEN81:
        if (take_len(b)) begin
          remain = sub_sat(remain, 2); ph = PH_SKIP81;
        end
      PH_SKIP81:
        if (fi == 0) fidx = 5'd1;
        else push_rec(KIND_FORMAT, 0, 0, ERR_NONE, 1);
      PH_HDR9: begin
        if (fi <= 3) rate = rate | (32'(b) << (8 * fi[1:0]));
        else if (fi == 4) bits = b;
        else if (fi == 5) chans = b;
        else if (fi <= 7) codec = codec | (16'(b) << (8 * (fi - 6)));
        if (fi == 7 && ((bits != 8 && bits != 16) || (codec != 0 && codec != 4)))
          push_rec(KIND_ERROR, 0, 0, ERR_CODEC, 0);
        else if (fi >= 11) push_rec(KIND_FORMAT, 0, 0, ERR_NONE, 1);
        else fidx = fi + 5'd1;
      end
      PH_DATA: begin
        push_rec(KIND_AUDIO, b, 0, ERR_NONE, 0);
        if (passed != 32'hFFFF_FFFF) passed = passed + 32'd1;
        if (remain > 0) remain = remain - 24'd1;
        if (remain == 0) ph = PH_BTYPE;
      end
      PH_BTYPE: begin
        remain = '0; fidx = '0;
        if (b == 2) ph = PH_LENC;
        else if (b >= 3 && b <= 7) ph = PH_LENS;
        else push_rec(KIND_END, 0, passed, ERR_NONE, 0);
      end
      PH_LENC:
        if (take_len(b)) ph = (remain != 0) ? PH_DATA : PH_BTYPE;
      PH_LENS:
        if (take_len(b)) ph = (remain != 0) ? PH_SKIP : PH_BTYPE;
      PH_SKIP: begin
        if (remain > 0) remain = remain - 24'd1;
        if (remain == 0) ph = PH_BTYPE;
      end
      default: ;
    endcase
    if (it.final_byte) begin
      if (ph == PH_BTYPE) push_rec(KIND_END, 0, passed, ERR_NONE, 0);
      else if (ph != PH_DONE) push_rec(KIND_ERROR, 0, 0, ERR_TRUNCATED, 0);
      clear_parser();
    end
    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].run_end = 1'b1;
  endfunction

  // stimulus building
  function automatic void put(logic [7:0] b, bit fin = 0);
    pending_bytes.push_back('{file_byte: b, final_byte: fin});
  endfunction

  function automatic void put_len(int unsigned l);
    put(l[7:0]); put(l[15:8]); put(l[23:16]);
  endfunction

  function automatic void put_head(logic [15:0] v = 16'h114);
    logic [15:0] chk;
    chk = ~v + 16'h1234;
    foreach (SIG[i]) put(SIG[i]);
    put(v[7:0]); put(v[15:8]); put(chk[7:0]); put(chk[15:8]);
  endfunction

  function automatic void put_data(int n);
    repeat (n) put(8'($urandom));
  endfunction

  // opening block: 1, 8 or 9 with n data bytes
  function automatic void put_open(int kindsel, int n);
    int unsigned r;
    case (kindsel)
      0: begin
        put(8'd1); put_len(n + 2); put(8'($urandom)); put(8'($urandom));
      end
      1: begin
        put(8'd8); put_len(4); put(8'($urandom)); put(8'($urandom));
        put(8'($urandom)); put(8'($urandom));
        put(8'd1); put_len(n + 2); put(8'($urandom)); put(8'($urandom));
      end
      default: begin
        r = $urandom;
        put(8'd9); put_len(n + 12);
        put(r[7:0]); put(r[15:8]); put(r[23:16]); put(r[31:24]);
        put($urandom_range(0, 1) ? 8'd16 : 8'd8); put(8'($urandom));
        put($urandom_range(0, 1) ? 8'd4 : 8'd0); put(8'd0);
        put_data(4);
      end
    endcase
    put_data(n);
  endfunction

  function automatic void put_random_file();
    int nblk;
    int sel;
    int cut;
    int start;
    start = pending_bytes.size();
    put_head($urandom_range(0, 1) ? 16'h10A : 16'h114);
    put_open($urandom_range(0, 2), $urandom_range(0, 6));
    nblk = $urandom_range(0, 3);
    repeat (nblk) begin
      sel = $urandom_range(0, 2);
      if (sel == 0) begin
        put(8'd2);
        cut = $urandom_range(0, 5); put_len(cut); put_data(cut);
      end else begin
        put(8'($urandom_range(3, 7)));
        cut = $urandom_range(0, 4); put_len(cut); put_data(cut);
      end
    end
    sel = $urandom_range(0, 9);
    if (sel < 5) put(8'($urandom_range(0, 1) ? 0 : $urandom_range(8, 255)), 1);
    else if (sel < 7) pending_bytes[pending_bytes.size() - 1].final_byte = 1;
    else begin
      // corrupted or truncated file
      cut = $urandom_range(start, pending_bytes.size() - 1);
      if ($urandom_range(0, 1)) pending_bytes[cut].file_byte = 8'($urandom);
      while (pending_bytes.size() > cut + 1) void'(pending_bytes.pop_back());
      pending_bytes[cut].final_byte = 1;
    end
    if ($urandom_range(0, 3) == 0) put(8'($urandom), 1);
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (in_taken) void'(pending_bytes.pop_front());
      if (!in_ch.valid || in_taken) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_bytes[0];
        end else in_ch.valid <= 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    result_t a;
    cycles <= cycles + 1;
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result kind=%0d", a.kind);
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (a !== e) begin
            errors <= errors + 1;
            if (a.kind !== e.kind) $error("kind exp %0d got %0d", e.kind, a.kind);
            if (a.audio_byte !== e.audio_byte)
              $error("audio_byte exp %0h got %0h", e.audio_byte, a.audio_byte);
            if (a.sample_rate !== e.sample_rate)
              $error("sample_rate exp %0d got %0d", e.sample_rate, a.sample_rate);
            if (a.bits_per_sample !== e.bits_per_sample)
              $error("bits_per_sample exp %0d got %0d", e.bits_per_sample,
                     a.bits_per_sample);
            if (a.channel_count !== e.channel_count)
              $error("channel_count exp %0d got %0d", e.channel_count, a.channel_count);
            if (a.format_tag !== e.format_tag)
              $error("format_tag exp %0h got %0h", e.format_tag, a.format_tag);
            if (a.first_block_bytes !== e.first_block_bytes)
              $error("first_block_bytes exp %0d got %0d", e.first_block_bytes,
                     a.first_block_bytes);
            if (a.data_total !== e.data_total)
              $error("data_total exp %0d got %0d", e.data_total, a.data_total);
            if (a.error_code !== e.error_code)
              $error("error_code exp %0d got %0d", e.error_code, a.error_code);
            if (a.run_end !== e.run_end)
              $error("run_end exp %0d got %0d", e.run_end, a.run_end);
          end
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int ph_sel;
    rst = 1'b1;
    cycles = 0;
    errors = 0;
    stim_done = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed
    put(8'h00, 1);
    put_head(16'h10A); put(8'd1); put_len(5);
    put(8'd0); put(8'd0); put(8'hFF); put(8'h00); put(8'h55); put(8'd0, 1);
    put_head(16'h114); put(8'd1); put_len(1); put(8'hFF); put(8'hFF);
    put(8'd2); put_len(2); put(8'hAA); put(8'h01);
    put(8'd5); put_len(1); put(8'h77); put(8'hFF, 1);
    put_head(); put(8'd8); put_len(4); put(8'hFF); put(8'hFF); put(8'h00);
    put(8'hFF); put(8'd1); put_len(3); put(8'h00); put(8'h00); put(8'h12);
    put(8'd2); put_len(0); put(8'd9, 1);
    put_head(); put(8'd8); put_len(4); put(8'h00); put(8'h00); put(8'h01);
    put(8'h00); put(8'd1); put_len(2); put(8'h00); put(8'h00, 1);
    put_head(); put(8'd9); put_len(14); put(8'h44); put(8'hAC); put(8'h00);
    put(8'h00); put(8'd16); put(8'd2); put(8'd4); put(8'd0); put_data(6); put(8'd0, 1);
    put(8'h43); put(8'h00); put(8'h11, 1);
    put_head(16'h115); put(8'h00, 1);
    foreach (SIG[i]) put(SIG[i]);
    put(8'h0A); put(8'h01); put(8'h00); put(8'h00); put(8'h00, 1);
    put_head(); put(8'd6, 1);
    put_head(); put(8'd8); put_len(5); put(8'h00, 1);
    put_head(); put(8'd8); put_len(4); put_data(4); put(8'd2, 1);
    put_head(); put(8'd9); put_len(12); put_data(4); put(8'd12); put(8'd1);
    put(8'd0); put(8'd0); put(8'd0, 1);
    put_head(); put(8'd9); put_len(12); put_data(4); put(8'd8); put(8'd1);
    put(8'd4); put(8'h80); put(8'd0, 1);
    put_head(); put(8'd1); put_len(4); put(8'd0); put(8'd0); put(8'h01, 1);
    put_head(); put(8'd1); put_len(2); put(8'd0); put(8'd0, 1);
    put_head(); put(8'd1); put_len(24'hFFFFFF); put(8'd0); put(8'd0); put_data(3);
    put(8'hFF, 1);

    for (ph_sel = 0; ph_sel < 4; ph_sel++) begin
      send_idle_pct = (ph_sel == 1 || ph_sel == 3) ? ((ph_sel == 1) ? 64 : 27) : 0;
      recv_stall_pct = (ph_sel == 2 || ph_sel == 3) ? ((ph_sel == 2) ? 64 : 27) : 0;
      repeat (6) put_random_file();
      repeat (3) put_data(1);
      pending_bytes[pending_bytes.size() - 1].final_byte = $urandom_range(0, 1);
      while (pending_bytes.size() > 0) @(posedge clk);
    end
    stim_done = 1;
    while (in_ch.valid || expected_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
